FILE: sv/tdpf_pkg.sv
`default_nettype none
package tdpf_pkg;

   // Store geometry
   localparam int QUEUE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;

   // Field widths
   localparam int MODE_W      = 3;
   localparam int TAG_W       = 16;
   localparam int LEN_W       = 16;
   localparam int STATUS_W    = 2;
   localparam int QCOUNT_W    = 11;
   localparam int BACKLOG_W   = 27;
   localparam int TOTAL_W     = 32;
   localparam int LIMIT_W     = 24;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = LIMIT_W;
   localparam int CMP_W       = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_MODE   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_LIMIT = CSR_IDX_W'(1);

   typedef enum logic [MODE_W-1:0] {
      OP_ENQUEUE   = 3'd0,
      OP_DEQUEUE   = 3'd1,
      OP_REQUEUE   = 3'd2,
      OP_DROP_TAIL = 3'd3,
      OP_PURGE     = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_DROPPED = 2'd1,
      ST_EMPTY   = 2'd2
   } status_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_EXEC = 1'b1
   } ctl_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch request, issue store read
      logic execute;   // apply operation, register result
   } dp_cmd_type;

   // Wrap a sum below twice the depth back into the store
   function automatic logic [IDX_W-1:0] wrap_slot(input logic [CNT_W-1:0] sum);
      logic [CNT_W-1:0] reduced;
      reduced = (sum >= CNT_W'(QUEUE_DEPTH)) ? sum - CNT_W'(QUEUE_DEPTH) : sum;
      return reduced[IDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: sv/tdpf_ctrl.sv
`default_nettype none
module tdpf_ctrl
   import tdpf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   output logic            rsp_strobe,
   output dp_cmd_type      dp_cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;
   logic          strobe_ff;

   // State register and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= CTL_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= dp_cmd.execute;
      end
   end

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      dp_cmd.capture = 1'b0;
      dp_cmd.execute = 1'b0;
      unique case (state_ff)
         CTL_IDLE: begin
            if (start) begin
               dp_cmd.capture = 1'b1;
               state_in       = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            dp_cmd.execute = 1'b1;
            state_in       = CTL_IDLE;
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   assign busy       = (state_ff == CTL_EXEC);
   assign rsp_strobe = strobe_ff;

endmodule
`default_nettype wire

FILE: sv/tdpf_datapath.sv
`default_nettype none
module tdpf_datapath
   import tdpf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dp_cmd_type            dp_cmd,
   input  wire logic [MODE_W-1:0]     req_mode,
   input  wire logic [TAG_W-1:0]      req_packet_tag,
   input  wire logic [LEN_W-1:0]      req_packet_len,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [TAG_W-1:0]           rsp_out_tag,
   output logic [LEN_W-1:0]           rsp_out_len,
   output logic [QCOUNT_W-1:0]        rsp_queued_count,
   output logic [BACKLOG_W-1:0]       rsp_backlog_bytes,
   output logic [TOTAL_W-1:0]         rsp_total_bytes,
   output logic [TOTAL_W-1:0]         rsp_total_packets,
   output logic [TOTAL_W-1:0]         rsp_total_drops
);

   // Descriptor store: tag in the upper half, length in the lower
   logic [TAG_W+LEN_W-1:0] store_mem [QUEUE_DEPTH];
   logic [TAG_W+LEN_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;

   // Queue state
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [BACKLOG_W-1:0] backlog_ff, backlog_in;
   logic [TOTAL_W-1:0]   bytes_ff, bytes_in;
   logic [TOTAL_W-1:0]   packets_ff, packets_in;
   logic [TOTAL_W-1:0]   drops_ff, drops_in;

   // Configuration
   logic               byte_mode_ff;
   logic [LIMIT_W-1:0] limit_ff;

   // Latched request
   logic [MODE_W-1:0] mode_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [LEN_W-1:0]  len_ff;

   // Result registers
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [TAG_W-1:0]     otag_ff, otag_in;
   logic [LEN_W-1:0]     olen_ff, olen_in;

   // Helpers
   logic               full;
   logic               admit;
   logic [CNT_W-1:0]   tail_sum;
   logic [IDX_W-1:0]   tail_slot;
   logic [IDX_W-1:0]   enq_slot;
   logic [IDX_W-1:0]   head_prev;
   logic [BACKLOG_W:0] backlog_plus;
   logic [LEN_W-1:0]   rd_len;
   logic [TAG_W-1:0]   rd_tag;

   // Slot of the last entry, from current state
   assign tail_sum  = CNT_W'(head_ff) + count_ff - CNT_W'(1);
   assign tail_slot = wrap_slot(tail_sum);
   assign enq_slot  = wrap_slot(CNT_W'(head_ff) + count_ff);
   assign head_prev = (head_ff == '0) ? IDX_W'(QUEUE_DEPTH - 1) : head_ff - IDX_W'(1);
   assign rd_addr   = (op_type'(req_mode) == OP_DEQUEUE) ? head_ff : tail_slot;

   assign rd_tag = rd_data_ff[TAG_W+LEN_W-1:LEN_W];
   assign rd_len = rd_data_ff[LEN_W-1:0];

   assign full         = (count_ff >= CNT_W'(QUEUE_DEPTH));
   assign backlog_plus = {1'b0, backlog_ff} + (BACKLOG_W+1)'(len_ff);
   assign admit = byte_mode_ff ?
                  (backlog_plus <= (BACKLOG_W+1)'(limit_ff)) :
                  (CMP_W'(count_ff) < CMP_W'(limit_ff));

   // Apply the latched operation
   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      backlog_in = backlog_ff;
      bytes_in   = bytes_ff;
      packets_in = packets_ff;
      drops_in   = drops_ff;
      status_in  = ST_DONE;
      otag_in    = '0;
      olen_in    = '0;
      wr_en      = 1'b0;
      wr_addr    = enq_slot;
      unique case (mode_ff)
         OP_ENQUEUE: begin
            if (admit && !full) begin
               wr_en      = 1'b1;
               count_in   = count_ff + CNT_W'(1);
               backlog_in = backlog_plus[BACKLOG_W-1:0];
               bytes_in   = bytes_ff + TOTAL_W'(len_ff);
               packets_in = packets_ff + TOTAL_W'(1);
            end else begin
               drops_in  = drops_ff + TOTAL_W'(1);
               status_in = ST_DROPPED;
            end
         end
         OP_DEQUEUE, OP_DROP_TAIL: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               otag_in    = rd_tag;
               olen_in    = rd_len;
               count_in   = count_ff - CNT_W'(1);
               backlog_in = backlog_ff - BACKLOG_W'(rd_len);
               if (mode_ff == OP_DEQUEUE) begin
                  head_in = wrap_slot(CNT_W'(head_ff) + CNT_W'(1));
               end
            end
         end
         OP_REQUEUE: begin
            if (full) begin
               drops_in  = drops_ff + TOTAL_W'(1);
               status_in = ST_DROPPED;
            end else begin
               wr_en      = 1'b1;
               wr_addr    = head_prev;
               head_in    = head_prev;
               count_in   = count_ff + CNT_W'(1);
               backlog_in = backlog_plus[BACKLOG_W-1:0];
            end
         end
         OP_PURGE: begin
            head_in    = '0;
            count_in   = '0;
            backlog_in = '0;
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   // Store write and registered read
   always_ff @(posedge clock) begin
      if (dp_cmd.execute && wr_en) begin
         store_mem[wr_addr] <= {tag_ff, len_ff};
      end
      if (dp_cmd.capture) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // Latch request
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         mode_ff <= req_mode;
         tag_ff  <= req_packet_tag;
         len_ff  <= req_packet_len;
      end
   end

   // Queue state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         backlog_ff   <= '0;
         bytes_ff     <= '0;
         packets_ff   <= '0;
         drops_ff     <= '0;
         byte_mode_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
      end else begin
         if (dp_cmd.execute) begin
            head_ff    <= head_in;
            count_ff   <= count_in;
            backlog_ff <= backlog_in;
            bytes_ff   <= bytes_in;
            packets_ff <= packets_in;
            drops_ff   <= drops_in;
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_BYTE_MODE:   byte_mode_ff <= csr_write_data[0];
               CSR_QUEUE_LIMIT: limit_ff     <= csr_write_data[LIMIT_W-1:0];
               default:         limit_ff     <= limit_ff;
            endcase
         end
      end
   end

   // Hold result of the transaction
   always_ff @(posedge clock) begin
      if (dp_cmd.execute) begin
         status_ff <= status_in;
         otag_ff   <= otag_in;
         olen_ff   <= olen_in;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_out_tag       = otag_ff;
   assign rsp_out_len       = olen_ff;
   assign rsp_queued_count  = QCOUNT_W'(count_ff);
   assign rsp_backlog_bytes = backlog_ff;
   assign rsp_total_bytes   = bytes_ff;
   assign rsp_total_packets = packets_ff;
   assign rsp_total_drops   = drops_ff;

endmodule
`default_nettype wire

FILE: sv/tail_drop_packet_fifo.sv
// Channel   Ports                                  Handshake
// request   req_mode, req_packet_tag, req_packet_len  start high, busy low
// response  rsp_* fields                           rsp_strobe, one cycle
// config    csr_index, csr_write_data              csr_write_enable
//
// Each transaction is split by the registered read port of the descriptor
// store: the accept cycle issues the store read, the next cycle applies the
// operation and registers the result. rsp_strobe rises the cycle after that,
// and a new transaction may be accepted in that same cycle, so a new request
// is taken only once the last one has been applied. Reset is synchronous and
// needs no clearing pass; the receiver cannot stall the response.
`default_nettype none
module tail_drop_packet_fifo
   import tdpf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [MODE_W-1:0]     req_mode,
   input  wire logic [TAG_W-1:0]      req_packet_tag,
   input  wire logic [LEN_W-1:0]      req_packet_len,
   output logic                       rsp_strobe,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [TAG_W-1:0]           rsp_out_tag,
   output logic [LEN_W-1:0]           rsp_out_len,
   output logic [QCOUNT_W-1:0]        rsp_queued_count,
   output logic [BACKLOG_W-1:0]       rsp_backlog_bytes,
   output logic [TOTAL_W-1:0]         rsp_total_bytes,
   output logic [TOTAL_W-1:0]         rsp_total_packets,
   output logic [TOTAL_W-1:0]         rsp_total_drops,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   dp_cmd_type dp_cmd;

   tdpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .dp_cmd     (dp_cmd)
   );

   tdpf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .dp_cmd            (dp_cmd),
      .req_mode          (req_mode),
      .req_packet_tag    (req_packet_tag),
      .req_packet_len    (req_packet_len),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_status        (rsp_status),
      .rsp_out_tag       (rsp_out_tag),
      .rsp_out_len       (rsp_out_len),
      .rsp_queued_count  (rsp_queued_count),
      .rsp_backlog_bytes (rsp_backlog_bytes),
      .rsp_total_bytes   (rsp_total_bytes),
      .rsp_total_packets (rsp_total_packets),
      .rsp_total_drops   (rsp_total_drops)
   );

endmodule
`default_nettype wire

FILE: sim/tail_drop_packet_fifo_tb.sv
`timescale 1ns / 100ps

import tdpf_pkg::*;

// One response as seen on the rsp_ ports
typedef struct packed {
   status_type           status;
   logic [TAG_W-1:0]     tag;
   logic [LEN_W-1:0]     len;
   logic [QCOUNT_W-1:0]  count;
   logic [BACKLOG_W-1:0] backlog;
   logic [TOTAL_W-1:0]   bytes;
   logic [TOTAL_W-1:0]   packets;
   logic [TOTAL_W-1:0]   drops;
} queue_report_type;

// Shadow copy of the descriptor queue and the responses it has promised
class queue_shadow;
   logic [TAG_W-1:0]     tag_mem [QUEUE_DEPTH];
   logic [LEN_W-1:0]     len_mem [QUEUE_DEPTH];
   int unsigned          head;
   int unsigned          held;
   logic [BACKLOG_W-1:0] bytes_held;
   logic [TOTAL_W-1:0]   byte_total;
   logic [TOTAL_W-1:0]   packet_total;
   logic [TOTAL_W-1:0]   drop_total;
   logic                 byte_limited;
   logic [LIMIT_W-1:0]   limit;
   queue_report_type     awaited[$];
   int unsigned          mismatches;

   function new();
      head         = 0;
      held         = 0;
      bytes_held   = '0;
      byte_total   = '0;
      packet_total = '0;
      drop_total   = '0;
      byte_limited = 1'b0;
      limit        = LIMIT_RESET;
      mismatches   = 0;
   endfunction

   function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      if (idx == CSR_BYTE_MODE) begin
         byte_limited = data[0];
      end else begin
         limit = data[LIMIT_W-1:0];
      end
   endfunction

   // Apply one accepted transaction and queue the response it must produce
   function void apply_op(logic [MODE_W-1:0] mode, logic [TAG_W-1:0] tag,
                          logic [LEN_W-1:0] len);
      queue_report_type r;
      logic             admit;
      logic             full;
      int unsigned      slot;
      r      = '0;
      r.status = ST_DONE;
      full   = (held >= QUEUE_DEPTH);
      case (mode)
         OP_ENQUEUE: begin
            if (byte_limited) begin
               admit = (longint'(bytes_held) + longint'(len)) <= longint'(limit);
            end else begin
               admit = held < limit;
            end
            if (admit && !full) begin
               slot          = (head + held) % QUEUE_DEPTH;
               tag_mem[slot] = tag;
               len_mem[slot] = len;
               held++;
               bytes_held    = bytes_held + len;
               byte_total    = byte_total + len;
               packet_total  = packet_total + 1;
            end else begin
               drop_total = drop_total + 1;
               r.status   = ST_DROPPED;
            end
         end
         OP_DEQUEUE, OP_DROP_TAIL: begin
            if (held == 0) begin
               r.status = ST_EMPTY;
            end else begin
               slot  = (mode == OP_DEQUEUE) ? head : (head + held - 1) % QUEUE_DEPTH;
               r.tag = tag_mem[slot];
               r.len = len_mem[slot];
               if (mode == OP_DEQUEUE) begin
                  head = (head + 1) % QUEUE_DEPTH;
               end
               held--;
               bytes_held = bytes_held - r.len;
            end
         end
         OP_REQUEUE: begin
            // bypasses the limit, only a full store refuses it
            if (full) begin
               drop_total = drop_total + 1;
               r.status   = ST_DROPPED;
            end else begin
               head          = (head + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
               tag_mem[head] = tag;
               len_mem[head] = len;
               held++;
               bytes_held    = bytes_held + len;
            end
         end
         OP_PURGE: begin
            head       = 0;
            held       = 0;
            bytes_held = '0;
         end
         default: begin
         end
      endcase
      r.count   = QCOUNT_W'(held);
      r.backlog = bytes_held;
      r.bytes   = byte_total;
      r.packets = packet_total;
      r.drops   = drop_total;
      awaited.push_back(r);
   endfunction

   function void check_field(string name, logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Compare a response against the oldest outstanding one
   function void match_response(queue_report_type got);
      queue_report_type want;
      if (awaited.size() == 0) begin
         $display("%0t: response with nothing outstanding, expected none actual %0h",
                  $time, got);
         mismatches++;
         return;
      end
      want = awaited.pop_front();
      check_field("status", want.status, got.status);
      check_field("out_tag", want.tag, got.tag);
      check_field("out_len", want.len, got.len);
      check_field("queued_count", want.count, got.count);
      check_field("backlog_bytes", want.backlog, got.backlog);
      check_field("total_bytes", want.bytes, got.bytes);
      check_field("total_packets", want.packets, got.packets);
      check_field("total_drops", want.drops, got.drops);
   endfunction
endclass

module tail_drop_packet_fifo_tb;

   localparam int STALL_LIMIT = 2000;
   localparam logic [MODE_W-1:0] MODE_UNUSED_LO = MODE_W'(OP_PURGE) + MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_UNUSED_HI = '1;
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;
   localparam logic [TAG_W-1:0] TAG_MAX = '1;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [MODE_W-1:0]     req_mode = '0;
   logic [TAG_W-1:0]      req_packet_tag = '0;
   logic [LEN_W-1:0]      req_packet_len = '0;
   logic                  rsp_strobe;
   logic [STATUS_W-1:0]   rsp_status;
   logic [TAG_W-1:0]      rsp_out_tag;
   logic [LEN_W-1:0]      rsp_out_len;
   logic [QCOUNT_W-1:0]   rsp_queued_count;
   logic [BACKLOG_W-1:0]  rsp_backlog_bytes;
   logic [TOTAL_W-1:0]    rsp_total_bytes;
   logic [TOTAL_W-1:0]    rsp_total_packets;
   logic [TOTAL_W-1:0]    rsp_total_drops;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   queue_shadow shadow = new();
   int          calm_left = 0;
   int          stall_cycles = 0;

   tail_drop_packet_fifo DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_packet_tag    (req_packet_tag),
      .req_packet_len    (req_packet_len),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_out_tag       (rsp_out_tag),
      .rsp_out_len       (rsp_out_len),
      .rsp_queued_count  (rsp_queued_count),
      .rsp_backlog_bytes (rsp_backlog_bytes),
      .rsp_total_bytes   (rsp_total_bytes),
      .rsp_total_packets (rsp_total_packets),
      .rsp_total_drops   (rsp_total_drops),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Check every response in the cycle it is strobed
   always @(posedge clock) begin
      queue_report_type seen;
      if (!reset && rsp_strobe) begin
         seen = '{status_type'(rsp_status), rsp_out_tag, rsp_out_len, rsp_queued_count,
                  rsp_backlog_bytes, rsp_total_bytes, rsp_total_packets, rsp_total_drops};
         shadow.match_response(seen);
      end
   end

   // End the run when neither side moves a transaction for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Mostly back to back, some short gaps, a few long ones, calm stretches
   function automatic int unsigned idle_cycles();
      int unsigned r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) calm_left = $urandom_range(20, 60);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) return OP_ENQUEUE;
      if (r < 68) return OP_DEQUEUE;
      if (r < 78) return OP_REQUEUE;
      if (r < 90) return OP_DROP_TAIL;
      if (r < 93) return OP_PURGE;
      return MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
   endfunction

   function automatic logic [LEN_W-1:0] pick_len();
      if ($urandom_range(0, 99) < 20) return LEN_W'($urandom);
      return LEN_W'($urandom_range(0, 400));
   endfunction

   // Hold the request until accepted, then note it and maybe idle
   task automatic issue_op(input logic [MODE_W-1:0] mode, input logic [TAG_W-1:0] tag,
                           input logic [LEN_W-1:0] len);
      int unsigned gap;
      start          <= 1'b1;
      req_mode       <= mode;
      req_packet_tag <= tag;
      req_packet_len <= len;
      @(posedge clock);
      while (busy) @(posedge clock);
      shadow.apply_op(mode, tag, len);
      gap = idle_cycles();
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic issue_random();
      issue_op(pick_mode(), TAG_W'($urandom), pick_len());
   endtask

   // Stop sending and wait for every outstanding response
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (shadow.awaited.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      shadow.write_register(idx, data);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic byte_mode, input logic [LIMIT_W-1:0] limit);
      drain();
      write_csr(CSR_BYTE_MODE, CSR_DATA_W'(byte_mode));
      write_csr(CSR_QUEUE_LIMIT, limit);
   endtask

   initial begin
      logic               phase_byte_mode [7];
      logic [LIMIT_W-1:0] phase_limit [7];

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Empty queue, field extremes, head requeue, undefined modes, purge
      issue_op(OP_DEQUEUE, '0, '0);
      issue_op(OP_DROP_TAIL, '0, '0);
      issue_op(OP_ENQUEUE, '0, '0);
      issue_op(OP_ENQUEUE, TAG_MAX, LEN_MAX);
      issue_op(OP_ENQUEUE, 16'hAAAA, 16'h5555);
      issue_op(OP_REQUEUE, 16'h5555, 16'hAAAA);
      issue_op(OP_DEQUEUE, '0, '0);
      issue_op(OP_DROP_TAIL, '0, '0);
      issue_op(MODE_UNUSED_LO, TAG_MAX, LEN_MAX);
      issue_op(MODE_UNUSED_HI, TAG_MAX, LEN_MAX);
      issue_op(OP_PURGE, '0, '0);
      issue_op(OP_DEQUEUE, '0, '0);

      // Zero packet limit refuses enqueue but not requeue
      configure(1'b0, '0);
      issue_op(OP_ENQUEUE, 16'h0101, 16'd10);
      issue_op(OP_REQUEUE, 16'h0202, 16'd20);
      issue_op(OP_ENQUEUE, 16'h0303, 16'd30);
      issue_op(OP_DROP_TAIL, '0, '0);
      issue_op(OP_PURGE, '0, '0);

      // Byte limit: exact fit, one over, zero length, requeue past the limit
      configure(1'b1, LIMIT_W'(100));
      issue_op(OP_ENQUEUE, 16'h1111, 16'd100);
      issue_op(OP_ENQUEUE, 16'h2222, 16'd1);
      issue_op(OP_ENQUEUE, 16'h3333, 16'd0);
      issue_op(OP_REQUEUE, 16'h4444, 16'd500);
      issue_op(OP_ENQUEUE, 16'h5555, 16'd0);
      issue_op(OP_PURGE, '0, '0);

      // Fill the store, then hit the full case on enqueue and requeue
      configure(1'b0, LIMIT_MAX);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         issue_op(OP_ENQUEUE, TAG_W'($urandom), pick_len());
      end
      issue_op(OP_ENQUEUE, TAG_MAX, LEN_MAX);
      issue_op(OP_REQUEUE, TAG_MAX, LEN_MAX);
      issue_op(OP_DROP_TAIL, '0, '0);
      issue_op(OP_REQUEUE, 16'h7777, 16'd7);
      issue_op(OP_DEQUEUE, '0, '0);
      issue_op(OP_DEQUEUE, '0, '0);
      issue_op(OP_PURGE, '0, '0);

      // Random traffic under several limit settings
      phase_byte_mode = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      phase_limit     = '{LIMIT_RESET, LIMIT_W'($urandom_range(1, 40)),
                          LIMIT_W'($urandom_range(200, 5000)), '0, '0, LIMIT_MAX,
                          LIMIT_W'(1)};
      for (int p = 0; p < 7; p++) begin
         configure(phase_byte_mode[p], phase_limit[p]);
         repeat (64) issue_random();
      end

      drain();
      if (shadow.mismatches == 0 && shadow.awaited.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/tdpf_pkg.sv
sv/tdpf_ctrl.sv
sv/tdpf_datapath.sv
sv/tail_drop_packet_fifo.sv
sim/tail_drop_packet_fifo_tb.sv
